### rtl/m6vm_pkg.sv
// package: sizes, item types and sequencer states of the 6x6 matrix vector multiplier
package m6vm_pkg;

  localparam int DIM       = 6;
  localparam int FRAC_BITS = 16;

  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FLD_W  = 3;
  localparam int IDX_W  = $clog2(DIM);
  localparam int CNT_W  = $clog2(DIM + 1);
  localparam int ADDR_W = $clog2(DIM * DIM);
  localparam int NENT   = DIM * DIM;

  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [FLD_W-1:0]        matrix_row;
    logic [FLD_W-1:0]        matrix_col;
    logic [FLD_W-1:0]        vector_index;
    logic signed [VAL_W-1:0] value;
    logic                    transposed;
    logic                    vector_last;
  } in_t;

  typedef struct packed {
    logic [FLD_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    saturated;
    logic                    last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

### rtl/mat6_vector_multiply_top.sv
// top level: 6x6 matrix store with one shared multiply-accumulate unit
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_ready_o   | in_data_i  (in_t)
//  out     | out | out_valid_o/out_ready_i | out_data_o (out_t)
//
// a matrix item is written without leaving idle; a vector item with an index
// inside the matrix busies the sequencer while the single multiplier, fed from
// the one-port matrix memory, works through DIM entries behind read and
// multiply stages; a vector item with vector_last then emits the DIM results in
// turn, stalling while out_ready_i is low
// reset clears the entry valid bits, so the matrix reads as zero at once
// in_ready_o is high only when the sequencer is idle
module mat6_vector_multiply_top
  import m6vm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  state_e state_q, state_d;

  logic [VAL_W-1:0]  mem [NENT];
  logic [NENT-1:0]   vld_q;
  logic [VAL_W-1:0]  rdata_q;
  logic              rvld_q;

  logic              trans_q;
  logic [IDX_W-1:0]  j_q;
  logic signed [VAL_W-1:0] vec_q;
  logic              last_q;

  logic [CNT_W-1:0]  iss_cnt_q;
  logic [CNT_W-1:0]  acc_cnt_q;
  logic [CNT_W-1:0]  emit_cnt_q;
  logic              rd_v_q, mul_v_q;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [ACC_W-1:0] acc_q [DIM];

  logic              out_valid_q;
  out_t              out_q;

  logic              accept;
  logic              wr_en;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              issue;
  logic [IDX_W-1:0]  iss_idx;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_new;
  logic              emit;
  logic              out_fit;
  logic signed [VAL_W-1:0]  out_sat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign wr_en       = accept && (in_data_i.op == OP_MATRIX) &&
                       (in_data_i.matrix_row < FLD_W'(DIM)) &&
                       (in_data_i.matrix_col < FLD_W'(DIM));
  assign waddr       = ADDR_W'(in_data_i.matrix_row) * ADDR_W'(DIM) +
                       ADDR_W'(in_data_i.matrix_col);

  assign issue       = (state_q == ST_MAC) && (iss_cnt_q < CNT_W'(DIM));
  assign iss_idx     = iss_cnt_q[IDX_W-1:0];
  assign raddr       = trans_q ? ADDR_W'(j_q) * ADDR_W'(DIM) + ADDR_W'(iss_idx)
                               : ADDR_W'(iss_idx) * ADDR_W'(DIM) + ADDR_W'(j_q);

  // floor shift of the product, sum against accumulator, clamp to 48 bits
  assign shifted     = prod_q >>> FRAC_BITS;
  assign sum         = SUM_W'(acc_q[0]) + SUM_W'(shifted);
  always_comb begin
    if ((&sum[SUM_W-1:ACC_W-1]) || !(|sum[SUM_W-1:ACC_W-1])) begin
      acc_new = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_new = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_new = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  assign emit    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign out_fit = (&acc_q[0][ACC_W-1:VAL_W-1]) || !(|acc_q[0][ACC_W-1:VAL_W-1]);
  always_comb begin
    if (out_fit) begin
      out_sat = acc_q[0][VAL_W-1:0];
    end else if (acc_q[0][ACC_W-1]) begin
      out_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.op == OP_VECTOR)) begin
          if (in_data_i.vector_index < FLD_W'(DIM)) begin
            state_d = ST_MAC;
          end else if (in_data_i.vector_last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MAC: begin
        if (mul_v_q && (acc_cnt_q == CNT_W'(DIM - 1))) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit && (emit_cnt_q == CNT_W'(DIM - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= in_data_i.value;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      trans_q <= in_data_i.transposed;
      j_q     <= in_data_i.vector_index[IDX_W-1:0];
      vec_q   <= in_data_i.value;
      last_q  <= in_data_i.vector_last;
    end
    if (rd_v_q) begin
      prod_q <= $signed(rvld_q ? rdata_q : '0) * vec_q;
    end
    if (emit) begin
      out_q.out_index   <= emit_cnt_q[FLD_W-1:0];
      out_q.out_value   <= out_sat;
      out_q.saturated   <= !out_fit;
      out_q.last_of_run <= (emit_cnt_q == CNT_W'(DIM - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      iss_cnt_q   <= '0;
      acc_cnt_q   <= '0;
      emit_cnt_q  <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < DIM; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        vld_q[waddr] <= 1'b1;
      end
      rvld_q  <= vld_q[raddr];
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
      if (accept) begin
        iss_cnt_q  <= '0;
        acc_cnt_q  <= '0;
        emit_cnt_q <= '0;
      end
      if (issue) begin
        iss_cnt_q <= iss_cnt_q + 1'b1;
      end
      // accumulators rotate so that the active one always sits at index 0
      if (mul_v_q) begin
        acc_cnt_q <= acc_cnt_q + 1'b1;
        for (int k = 0; k < DIM - 1; k++) begin
          acc_q[k] <= acc_q[k+1];
        end
        acc_q[DIM-1] <= acc_new;
      end else if (emit) begin
        emit_cnt_q <= emit_cnt_q + 1'b1;
        for (int k = 0; k < DIM - 1; k++) begin
          acc_q[k] <= acc_q[k+1];
        end
        acc_q[DIM-1] <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/m6vm_chk.sv
// checker: port-level properties of the matrix vector multiplier, bound to the top level
module m6vm_chk
  import m6vm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a vector item with a valid index busies the sequencer
  a_vec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OP_VECTOR) &&
    (in_data_i.vector_index < FLD_W'(DIM)) |=> !in_ready_o)
    else $error("ready after vector item");

  // a matrix write leaves the sequencer ready in the next cycle
  a_mat_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OP_MATRIX) |=> in_ready_o)
    else $error("matrix item not done in one cycle");

  // input held off until a run is fully emitted
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> !in_ready_o)
    else $error("input taken during emission");

  // clipped results sit at a range limit
  a_sat_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
    (out_data_o.out_value == {1'b0, {(VAL_W-1){1'b1}}}) ||
    (out_data_o.out_value == {1'b1, {(VAL_W-1){1'b0}}}))
    else $error("saturated result off the limits");

endmodule

bind mat6_vector_multiply_top m6vm_chk u_m6vm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### tb/sv/testbench.sv
// testbench: streams matrix and vector items through the 6x6 multiplier and checks every result item
`timescale 1ns / 100ps

module testbench
  import m6vm_pkg::*;
;

  localparam int  ITEM_GOAL    = 350;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam longint ACC_MAX   = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam longint OUT_MAX   = (longint'(1) <<< (VAL_W - 1)) - 1;
  localparam longint OUT_MIN   = -OUT_MAX - 1;

  class matvec_product_model;
    logic signed [VAL_W-1:0] a_store [DIM][DIM];
    longint                  acc [DIM];
    out_t                    pending_results [$];
    int                      mismatches;
    int                      results_seen;
    int                      clipped_seen;

    function new();
      for (int r = 0; r < DIM; r++) begin
        acc[r] = 0;
        for (int c = 0; c < DIM; c++) a_store[r][c] = '0;
      end
      mismatches   = 0;
      results_seen = 0;
      clipped_seen = 0;
    endfunction

    function void note_item(in_t it);
      longint a;
      longint prod;
      longint total;
      longint clip;
      out_t   res;
      int     j;
      if (it.op == OP_MATRIX) begin
        if (it.matrix_row < DIM && it.matrix_col < DIM)
          a_store[it.matrix_row][it.matrix_col] = it.value;
        return;
      end
      j = int'(it.vector_index);
      if (j < DIM) begin
        for (int i = 0; i < DIM; i++) begin
          a = it.transposed ? longint'($signed(a_store[j][i]))
                            : longint'($signed(a_store[i][j]));
          prod  = (a * longint'($signed(it.value))) >>> FRAC_BITS;
          total = acc[i] + prod;
          acc[i] = total > ACC_MAX ? ACC_MAX : (total < ACC_MIN ? ACC_MIN : total);
        end
      end
      if (!it.vector_last) return;
      for (int i = 0; i < DIM; i++) begin
        clip = acc[i] > OUT_MAX ? OUT_MAX : (acc[i] < OUT_MIN ? OUT_MIN : acc[i]);
        res.out_index   = FLD_W'(i);
        res.out_value   = VAL_W'(clip);
        res.saturated   = (clip != acc[i]);
        res.last_of_run = (i == DIM - 1);
        pending_results.push_back(res);
        acc[i] = 0;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item index %0d value %h", $time,
                 got.out_index, got.out_value);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (want.saturated) clipped_seen++;
      if (got.out_index !== want.out_index) begin
        $display("%0t: out_index expected %0d got %0d", $time, want.out_index, got.out_index);
        mismatches++;
      end
      if (got.out_value !== want.out_value) begin
        $display("%0t: out_value expected %h got %h", $time, want.out_value, got.out_value);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b got %b", $time, want.saturated, got.saturated);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %b got %b", $time, want.last_of_run,
                 got.last_of_run);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  matvec_product_model products;
  int  items_sent;
  int  cycles;
  bit  calm_tail;
  bit  held_once;

  mat6_vector_multiply_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) products.note_item(in_data_i);
      if (out_valid_o && out_ready_i) products.check_result(out_data_o);
    end
  end

  // receiver: random stall bursts, one long hold-off so the block backs up
  initial begin
    out_ready_i = 1'b0;
    held_once   = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held_once && products.results_seen >= 40) begin
        out_ready_i <= 1'b0;
        held_once = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return $urandom;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic int rand_slot();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, DIM - 1);
  endfunction

  function automatic in_t mat_item(int r, int c, logic [VAL_W-1:0] v);
    in_t it;
    it.op           = OP_MATRIX;
    it.matrix_row   = FLD_W'(r);
    it.matrix_col   = FLD_W'(c);
    it.vector_index = FLD_W'($urandom_range(0, 7));
    it.value        = v;
    it.transposed   = 1'($urandom_range(0, 1));
    it.vector_last  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_t vec_item(int j, logic [VAL_W-1:0] v, bit t, bit last);
    in_t it;
    it.op           = OP_VECTOR;
    it.matrix_row   = FLD_W'($urandom_range(0, 7));
    it.matrix_col   = FLD_W'($urandom_range(0, 7));
    it.vector_index = FLD_W'(j);
    it.value        = v;
    it.transposed   = t;
    it.vector_last  = last;
    return it;
  endfunction

  task automatic offer(in_t it);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic vector_run();
    int order [DIM];
    int len;
    int pick;
    int tmp;
    bit t;
    bit mixed;
    bit tidy;
    t     = 1'($urandom_range(0, 1));
    mixed = ($urandom_range(0, 5) == 0);
    tidy  = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < DIM; k++) order[k] = k;
    for (int k = DIM - 1; k > 0; k--) begin
      pick        = $urandom_range(0, k);
      tmp         = order[k];
      order[k]    = order[pick];
      order[pick] = tmp;
    end
    len = tidy ? DIM : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0) offer(mat_item(rand_slot(), rand_slot(), rand_value()));
      offer(vec_item(tidy ? order[k] : $urandom_range(0, 7), rand_value(),
                     mixed ? 1'($urandom_range(0, 1)) : t, k == len - 1));
    end
  endtask

  task automatic noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    offer(raw[$bits(in_t)-1:0]);
  endtask

  initial begin
    in_t it;
    products    = new();
    items_sent  = 0;
    calm_tail   = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // last item with nothing accumulated
    offer(vec_item(0, 32'h0000_0005, 1'b0, 1'b1));
    offer(mat_item(0, 0, 32'h7FFF_FFFF));
    offer(mat_item(5, 5, 32'h8000_0000));
    offer(mat_item(0, 5, 32'h7FFF_FFFF));
    offer(mat_item(5, 0, 32'hFFFF_0000));
    offer(mat_item(2, 1, 32'hFFFF_FFFF));
    it = mat_item(3, 4, 32'h0001_8000);
    it.vector_last = 1'b1;
    it.transposed  = 1'b1;
    offer(it);
    // writes outside the matrix
    offer(mat_item(6, 0, 32'h0000_1234));
    offer(mat_item(0, 7, 32'h0000_5678));
    offer(mat_item(7, 7, 32'hFFFF_FFFF));
    // mixed orientation, floor rounding, index past the end carrying last
    offer(vec_item(0, 32'h7FFF_FFFF, 1'b0, 1'b0));
    offer(vec_item(1, 32'h0000_0001, 1'b0, 1'b0));
    offer(vec_item(3, 32'h0002_0000, 1'b1, 1'b0));
    offer(vec_item(6, 32'h1234_5678, 1'b0, 1'b1));
    // accumulator clipping both ways, matrix write inside a run
    offer(vec_item(5, 32'h8000_0000, 1'b0, 1'b0));
    offer(vec_item(5, 32'h8000_0000, 1'b0, 1'b0));
    offer(mat_item(1, 5, 32'h0001_0000));
    offer(vec_item(5, 32'h8000_0000, 1'b0, 1'b0));
    offer(vec_item(7, 32'h0000_0001, 1'b1, 1'b1));
    offer(vec_item(6, 32'h0000_0001, 1'b0, 1'b1));

    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= ITEM_GOAL - 50) calm_tail = 1'b1;
      case ($urandom_range(0, 9))
        0: noise_item();
        1, 2: repeat ($urandom_range(1, 4))
          offer(mat_item(rand_slot(), rand_slot(), rand_value()));
        default: vector_run();
      endcase
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (products.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("ran %0d input items and %0d result items, %0d of them clipped",
             items_sent, products.results_seen, products.clipped_seen);
    $display("receiver hold-off of %0d cycles taken: %0d", HOLD_CYCLES, held_once);
    if (products.mismatches == 0 && products.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
